/* rtl/sad_pkg.sv */
// Shared types and constants for the sorted array dictionary.
// Holds operation and status codes, field widths and the cell command types.
// No dependencies; compiled first.
`default_nettype none

package sad_pkg;

  localparam int unsigned SAD_DEPTH = 128;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned COUNT_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_SEARCH = 3'd1,
    OP_DELETE = 3'd2,
    OP_PRED   = 3'd3,
    OP_SUCC   = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_NOT_FOUND   = 2'd1,
    ST_FULL        = 2'd2,
    ST_NO_NEIGHBOR = 2'd3
  } status_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    ins_en;  // commit an insert this cycle
    logic                    del_en;  // commit a delete this cycle
    logic                    ins_sel; // mark insert slot, else first match
    logic                    pred;    // pick left neighbor, else right
  } cell_cmd_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    gt;  // occupied and greater than the request key
    logic                    eq;  // occupied and equal to the request key
  } cell_view_t;

endpackage

`default_nettype wire

/* rtl/sad_if.sv */
// Valid/ready channel interfaces for request and result beats.
// Depends on sad_pkg for field widths.
`default_nettype none

interface sad_req_if import sad_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, op, key, input ready);
  modport sink   (input valid, op, key, output ready);
endinterface

interface sad_rsp_if import sad_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [POS_W-1:0]        position;
  logic signed [KEY_W-1:0] neighbor;
  logic [COUNT_W-1:0]      entry_count;
  logic signed [KEY_W-1:0] smallest;
  logic signed [KEY_W-1:0] largest;

  modport source (output valid, status, position, neighbor, entry_count, smallest, largest,
                  input ready);
  modport sink   (input valid, status, position, neighbor, entry_count, smallest, largest,
                  output ready);
endinterface

`default_nettype wire

/* rtl/sad_cell.sv */
// One slot of the sorted row: holds a key, compares it with the request
// and shifts left or right with its neighbors. Depends on sad_pkg.
`default_nettype none

module sad_cell import sad_pkg::*; (
  input  logic                    clk,
  input  cell_cmd_t               cmd,
  input  logic                    occ,      // slot lies below the entry count
  input  logic                    at_end,   // slot index equals the entry count
  input  cell_view_t              left,
  input  logic signed [KEY_W-1:0] right_key,
  output cell_view_t              view,
  output logic                    sel,
  output logic signed [KEY_W-1:0] pick_key
);

  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_nxt;
  logic                    gt;
  logic                    eq;
  logic                    ins_here;
  logic                    first_eq;

  assign gt       = occ && (key_r > cmd.key);
  assign eq       = occ && (key_r == cmd.key);
  // Insert goes after all equal entries: first greater slot, or the end.
  assign ins_here = !left.gt && (gt || at_end);
  assign first_eq = eq && !left.eq;

  assign view     = '{key: key_r, gt: gt, eq: eq};
  assign sel      = cmd.ins_sel ? ins_here : first_eq;
  assign pick_key = cmd.pred ? left.key : right_key;

  always_comb begin
    key_nxt = key_r;
    if (cmd.ins_en) begin
      if (left.gt) begin
        key_nxt = left.key;
      end else if (ins_here) begin
        key_nxt = cmd.key;
      end
    end else if (cmd.del_en) begin
      // slots at or past the match close the gap
      if (gt || eq) begin
        key_nxt = right_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

`default_nettype wire

/* rtl/sorted_array_dictionary.sv */
// Sorted array dictionary of signed 32-bit keys, duplicates allowed.
// Request channel in_chan carries op (insert, search, delete, predecessor,
// successor) and key; result channel out_chan returns status, position,
// neighbor, entry_count, smallest and largest after the step.
// Keys live in a row of DEPTH cells; every cell compares its key with the
// request at once and shifts with its neighbors, so an update is done in the
// execute state alone, regardless of where the key lands.
// Each request passes in order through the idle, execute and load states;
// one request is in flight at a time, so the next is taken only after the
// last is loaded. in_chan.ready rises again as soon as the result is loaded,
// even while that result still waits on out_chan.
// If the receiver stalls, the result register holds its beat; the next
// request is executed and then waits in the load stage until the register
// frees up.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// beat; key storage is not cleared, since only slots below the count are read.
// Unused op codes leave the table alone and return status ok with zero position and neighbor.
`default_nettype none

module sorted_array_dictionary import sad_pkg::*; #(
  parameter int unsigned DEPTH = SAD_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  sad_req_if.sink   in_chan,
  sad_rsp_if.source out_chan
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LOAD} state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        count_r;
  logic [OP_W-1:0]         req_op_r;
  logic signed [KEY_W-1:0] req_key_r;
  logic [STAT_W-1:0]       res_status_r;
  logic [IDX_W-1:0]        res_pos_r;
  logic signed [KEY_W-1:0] res_nb_r;

  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r;
  logic [POS_W-1:0]        out_pos_r;
  logic signed [KEY_W-1:0] out_nb_r;
  logic [COUNT_W-1:0]      out_count_r;
  logic signed [KEY_W-1:0] out_min_r;
  logic signed [KEY_W-1:0] out_max_r;

  cell_cmd_t               cmd;
  cell_view_t              view    [DEPTH];
  cell_view_t              left_v  [DEPTH];
  logic signed [KEY_W-1:0] right_k [DEPTH];
  logic signed [KEY_W-1:0] pick_k  [DEPTH];
  logic [DEPTH-1:0]        sel;
  logic [DEPTH:0]          occ;
  logic [DEPTH-1:0]        at_end;

  logic                    full;
  logic                    found;
  logic                    succ_ok;
  logic [IDX_W-1:0]        sel_pos;
  logic signed [KEY_W-1:0] sel_nb;
  logic signed [KEY_W-1:0] max_key;
  logic [STAT_W-1:0]       exec_status;
  logic [IDX_W-1:0]        exec_pos;
  logic signed [KEY_W-1:0] exec_nb;
  logic                    exec;
  logic                    out_free;

  assign exec     = (state_r == S_EXEC);
  assign out_free = !out_valid_r || out_chan.ready;
  assign full     = (count_r == CNT_W'(DEPTH));

  assign cmd.key     = req_key_r;
  assign cmd.ins_sel = (req_op_r == OP_INSERT);
  assign cmd.pred    = (req_op_r == OP_PRED);
  assign cmd.ins_en  = exec && (req_op_r == OP_INSERT) && !full;
  assign cmd.del_en  = exec && (req_op_r == OP_DELETE) && found;

  assign occ[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i]    = (CNT_W'(i) < count_r);
    assign at_end[i] = (count_r == CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_v[i] = '{key: '0, gt: 1'b0, eq: 1'b0};
    end else begin : g_mid
      assign left_v[i] = view[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_k[i] = view[i].key;
    end else begin : g_inner
      assign right_k[i] = view[i+1].key;
    end

    sad_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ[i]),
      .at_end    (at_end[i]),
      .left      (left_v[i]),
      .right_key (right_k[i]),
      .view      (view[i]),
      .sel       (sel[i]),
      .pick_key  (pick_k[i])
    );
  end

  // Collapse the one-hot cell marks into index, neighbor and flags.
  always_comb begin
    found   = 1'b0;
    succ_ok = 1'b0;
    sel_pos = '0;
    sel_nb  = '0;
    max_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found   = found | (view[i].eq && !left_v[i].eq);
      succ_ok = succ_ok | (sel[i] && occ[i+1]);
      sel_pos = sel_pos | (sel[i] ? IDX_W'(i) : '0);
      sel_nb  = sel_nb | (sel[i] ? pick_k[i] : '0);
      max_key = max_key | ((occ[i] && !occ[i+1]) ? view[i].key : '0);
    end
  end

  always_comb begin
    exec_status = ST_OK;
    exec_pos    = '0;
    exec_nb     = '0;
    case (req_op_r)
      OP_INSERT: begin
        if (full) begin
          exec_status = ST_FULL;
        end else begin
          exec_pos = sel_pos;
        end
      end
      OP_SEARCH, OP_DELETE: begin
        if (found) begin
          exec_pos = sel_pos;
        end else begin
          exec_status = ST_NOT_FOUND;
        end
      end
      OP_PRED: begin
        if (!found) begin
          exec_status = ST_NOT_FOUND;
        end else if (sel[0]) begin
          exec_status = ST_NO_NEIGHBOR;
        end else begin
          exec_pos = sel_pos;
          exec_nb  = sel_nb;
        end
      end
      OP_SUCC: begin
        if (!found) begin
          exec_status = ST_NOT_FOUND;
        end else if (!succ_ok) begin
          exec_status = ST_NO_NEIGHBOR;
        end else begin
          exec_pos = sel_pos;
          exec_nb  = sel_nb;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the load stage sets or holds valid itself
      if (out_valid_r && out_chan.ready && state_r != S_LOAD) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            req_op_r  <= in_chan.op;
            req_key_r <= in_chan.key;
            state_r   <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status_r <= exec_status;
          res_pos_r    <= exec_pos;
          res_nb_r     <= exec_nb;
          if (cmd.ins_en) begin
            count_r <= count_r + CNT_W'(1);
          end else if (cmd.del_en) begin
            count_r <= count_r - CNT_W'(1);
          end
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          // wait for the result register to free up
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_pos_r    <= POS_W'(res_pos_r);
            out_nb_r     <= res_nb_r;
            out_count_r  <= COUNT_W'(count_r);
            out_min_r    <= occ[0] ? view[0].key : '0;
            out_max_r    <= max_key;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.position    = out_pos_r;
  assign out_chan.neighbor    = out_nb_r;
  assign out_chan.entry_count = out_count_r;
  assign out_chan.smallest    = out_min_r;
  assign out_chan.largest     = out_max_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> $onehot0(sel))
    else $error("more than one cell selected");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_en |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the table");

  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.del_en |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("delete did not shrink the table");

  a_found_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && !cmd.ins_sel) |-> (found == (sel != '0)))
    else $error("match flag and match mark disagree");

endmodule

`default_nettype wire
